FILE: rtl/dio_pkg.sv
package dio_pkg;

  localparam int AtanCount = 24;
  localparam logic [31:0] ATAN_TURNS [AtanCount] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ZERO  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

endpackage

FILE: rtl/dual_imu_encoder_odometry.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_data (inches_per_tick, Q4.16)
// in        in         in_valid/in_ready      func, count_*, imu_a/b_heading
// out       out        out_valid/out_ready    heading_cdeg, positions, steps
//
// A transfer keeps the sequencer busy, taking no new input, until it is done.
// When the two headings cancel, the vectoring pass is skipped. The work falls
// to the one shared CORDIC iteration stage, which runs up to four passes in turn
// (two sin/cos, one vectoring, one at the mean heading) for a tick, the first
// three for a zero and none for the other commands, and to the one 36x24
// multiplier that serves the heading conversions and the inch scaling; the
// rotation products use small 33x16 multipliers. Reset is synchronous and
// clears the control state, the last counts, heading, offset and positions, but
// not the datapath or output data. A result waits in the output register until
// taken while the sequencer goes back to idle and takes the next input; a
// finished item waits in its last state only while the previous result is still
// untaken.
module dual_imu_encoder_odometry
  import dio_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] count_left,
  input  logic signed [31:0] count_right,
  input  logic signed [31:0] count_middle,
  input  logic [15:0]        imu_a_heading,
  input  logic [15:0]        imu_b_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        heading_cdeg,
  output logic signed [47:0] x_ticks,
  output logic signed [47:0] y_ticks,
  output logic signed [47:0] x_inches,
  output logic signed [47:0] y_inches,
  output logic signed [31:0] step_left,
  output logic signed [31:0] step_right,
  output logic signed [31:0] step_middle
);

  localparam int IterW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MIRA, S_MIRB, S_SUBOFF, S_SCA_INIT, S_SCA_RUN, S_SCA_DONE,
    S_SCB_INIT, S_SCB_RUN, S_SCB_DONE, S_VEC_INIT, S_VEC_RUN, S_VEC_DONE,
    S_AVG_RUN, S_AVG_DONE, S_PROD, S_ACC, S_CDEG
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic [19:0] ipt;
  logic signed [31:0] prev_left, prev_right, prev_middle;
  logic signed [31:0] st_left, st_right, st_middle;
  logic [15:0] prev_heading, heading_offset;
  logic signed [47:0] acc_xt, acc_yt, acc_xi, acc_yi;
  logic [15:0] hdg_a, hdg_b, ma, mb;
  logic signed [32:0] dl, dr, dm;
  logic [IterW-1:0] iter;
  logic [4:0] sub;
  logic res_load;

  // CORDIC datapath (shared by rotation and vectoring)
  logic signed [35:0] cx, cy;
  logic signed [32:0] cz;
  logic               cflip, vec_mode;
  logic signed [15:0] ca, sa, cc, sc;
  logic signed [17:0] sum_x, sum_y;
  logic [15:0] theta;

  // Multiply unit
  logic [35:0] mul_a;
  logic [23:0] mul_b;
  logic [59:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Scaling work registers
  logic signed [63:0] tx, ty, ux, uy;
  logic signed [63:0] p1;

  logic [4:0] atan_idx;
  logic [31:0] atan_v;
  assign atan_idx = 5'(iter);
  assign atan_v = ATAN_TURNS[atan_idx];

  // One CORDIC iteration
  logic signed [35:0] xs, ys, cx_next, cy_next;
  logic signed [32:0] cz_next;
  logic dir_pos;
  always_comb begin
    xs = cx >>> iter;
    ys = cy >>> iter;
    dir_pos = vec_mode ? (cy >= 0) : (cz >= 0);
    if (vec_mode) begin
      if (dir_pos) begin
        cx_next = cx + ys; cy_next = cy - xs; cz_next = cz + $signed({1'b0, atan_v});
      end else begin
        cx_next = cx - ys; cy_next = cy + xs; cz_next = cz - $signed({1'b0, atan_v});
      end
    end else begin
      if (dir_pos) begin
        cx_next = cx - ys; cy_next = cy + xs; cz_next = cz - $signed({1'b0, atan_v});
      end else begin
        cx_next = cx + ys; cy_next = cy - xs; cz_next = cz + $signed({1'b0, atan_v});
      end
    end
  end

  // Rounding of the CORDIC result to Q1.15 with clamp and flip
  function automatic logic signed [15:0] fin15(input logic signed [35:0] v,
                                                input logic flip);
    logic signed [35:0] r;
    logic signed [15:0] c;
    r = (v + 36'sd16384) >>> 15;
    if (r > 36'sd32767) c = 16'sd32767;
    else if (r < -36'sd32767) c = -16'sd32767;
    else c = 16'(r);
    return flip ? -c : c;
  endfunction

  // Rotation start from a 16-bit turn angle
  logic [15:0] rot_ang;
  logic signed [32:0] z0;
  logic flip0;
  always_comb begin
    z0 = 33'(signed'({rot_ang, 16'h0000}));
    flip0 = 1'b0;
    if (z0 > 33'sh040000000) begin
      z0 = z0 - 33'sh080000000; flip0 = 1'b1;
    end else if (z0 < -33'sh040000000) begin
      z0 = z0 + 33'sh080000000; flip0 = 1'b1;
    end
  end

  // Scale one 64-bit value by inches_per_tick (magnitude split into halves)
  logic signed [63:0] sc_val;
  logic [63:0] sc_mag, sc_hi_p, sc_ins, sc_tik;
  logic sc_neg;

  logic [16:0] mir;
  logic [15:0] mir_h;
  assign mir_h = (sub == 5'd0) ? hdg_a : hdg_b;
  assign mir = (mir_h <= 16'd36000) ? 17'(17'd36000 - mir_h) : 17'(mir_h - 17'd36000);

  logic [16:0] avg17;
  assign avg17 = ({1'b0, theta} + {1'b0, prev_heading}) >> 1;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE) && !cfg_valid;

  // The finished item moves into the output register once that register is free.
  assign res_load = (state == S_CDEG) && (!out_valid || out_ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MIRA, S_MIRB: begin
        mul_a = 36'({mir, 16'h0000} + 33'd18000);
        mul_b = 24'd7635497;
      end
      S_CDEG: begin
        mul_a = 36'(prev_heading);
        mul_b = 24'd36000;
      end
      S_ACC: begin
        mul_a = 36'(sc_mag[31:0]);
        mul_b = 24'(ipt);
      end
      S_PROD: begin
        mul_a = 36'(sc_mag[63:32]);
        mul_b = 24'(ipt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // (m*65536+18000)/36000 = floor(v * 7635497 / 2^38) with a one-step fix
  logic [33:0] mir_v;
  logic [21:0] mir_q;
  logic [36:0] mir_rem;
  assign mir_v = 34'({mir, 16'h0000} + 33'd18000);
  assign mir_q = 22'(mul_p >> 38);
  assign mir_rem = 37'(mir_v) - 37'(mir_q) * 37'd36000;

  assign sc_val = (sub[1:0] == 2'd0) ? ux : (sub[1:0] == 2'd1) ? uy :
                  (sub[1:0] == 2'd2) ? tx : ty;
  assign sc_neg = sc_val < 0;
  assign sc_mag = sc_neg ? 64'(-sc_val) : 64'(sc_val);
  assign sc_ins = sc_hi_p + ((64'(mul_p) + 64'h8000) >> 16);
  assign sc_tik = (sc_mag + 64'd64) >> 7;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      ipt <= 20'd1573;
      prev_left <= '0; prev_right <= '0; prev_middle <= '0;
      prev_heading <= '0; heading_offset <= '0;
      acc_xt <= '0; acc_yt <= '0; acc_xi <= '0; acc_yi <= '0;
      iter <= '0; sub <= '0; cmd <= FUNC_NONE;
      vec_mode <= 1'b0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            ipt <= cfg_data;
          end else if (in_valid) begin
            cmd <= func;
            hdg_a <= imu_a_heading;
            hdg_b <= imu_b_heading;
            if (func == FUNC_TICK) begin
              st_left <= count_left - prev_left;
              st_right <= count_right - prev_right;
              st_middle <= count_middle - prev_middle;
              dl <= 33'(signed'(count_left - prev_left));
              dr <= 33'(signed'(count_right - prev_right));
              dm <= 33'(signed'(count_middle - prev_middle));
              prev_left <= count_left;
              prev_right <= count_right;
              prev_middle <= count_middle;
            end else begin
              st_left <= '0; st_right <= '0; st_middle <= '0;
            end
            if (func == FUNC_CLEAR) begin
              acc_xt <= '0; acc_yt <= '0; acc_xi <= '0; acc_yi <= '0;
            end
            sub <= '0;
            if (func == FUNC_TICK || func == FUNC_ZERO) state <= S_MIRA;
            else state <= S_CDEG;
          end
        end
        S_MIRA, S_MIRB: begin
          if (mir_rem >= 37'd36000) begin
            if (state == S_MIRA) ma <= 16'(mir_q + 22'd1);
            else mb <= 16'(mir_q + 22'd1);
          end else begin
            if (state == S_MIRA) ma <= 16'(mir_q);
            else mb <= 16'(mir_q);
          end
          sub <= 5'd1;
          state <= (state == S_MIRA) ? S_MIRB : S_SUBOFF;
        end
        S_SUBOFF: begin
          if (cmd == FUNC_TICK) begin
            ma <= ma - heading_offset;
            mb <= mb - heading_offset;
          end
          state <= S_SCA_INIT;
        end
        S_SCA_INIT, S_SCB_INIT: begin
          cx <= CORDIC_GAIN;
          cy <= '0;
          cz <= z0;
          cflip <= flip0;
          vec_mode <= 1'b0;
          iter <= '0;
          state <= (state == S_SCA_INIT) ? S_SCA_RUN :
                   (state == S_SCB_INIT) ? S_SCB_RUN : S_AVG_RUN;
        end
        S_SCA_RUN, S_SCB_RUN, S_VEC_RUN, S_AVG_RUN: begin
          cx <= cx_next; cy <= cy_next; cz <= cz_next;
          iter <= iter + 1'b1;
          if (iter == IterW'(CORDIC_STEPS - 1)) begin
            state <= (state == S_SCA_RUN) ? S_SCA_DONE :
                     (state == S_SCB_RUN) ? S_SCB_DONE :
                     (state == S_VEC_RUN) ? S_VEC_DONE : S_AVG_DONE;
          end
        end
        S_SCA_DONE: begin
          ca <= fin15(cx, cflip);
          sa <= fin15(cy, cflip);
          state <= S_SCB_INIT;
        end
        S_SCB_DONE: begin
          sum_x <= 18'(ca) + 18'(fin15(cx, cflip));
          sum_y <= 18'(sa) + 18'(fin15(cy, cflip));
          state <= S_VEC_INIT;
        end
        S_VEC_INIT: begin
          vec_mode <= 1'b1;
          iter <= '0;
          if (sum_x == 0 && sum_y == 0) begin
            cz <= 33'sh080000000;
            state <= S_VEC_DONE;
          end else if (sum_x < 0) begin
            cx <= -(36'(sum_x) <<< 14);
            cy <= -(36'(sum_y) <<< 14);
            cz <= 33'sh080000000;
            state <= S_VEC_RUN;
          end else begin
            cx <= 36'(sum_x) <<< 14;
            cy <= 36'(sum_y) <<< 14;
            cz <= '0;
            state <= S_VEC_RUN;
          end
        end
        S_VEC_DONE: begin
          theta <= 16'((32'(cz) + 32'h8000) >> 16);
          if (cmd == FUNC_ZERO) begin
            heading_offset <= 16'((32'(cz) + 32'h8000) >> 16);
            state <= S_CDEG;
          end else begin
            state <= S_AVG_DONE;
            sub <= 5'd31;
          end
        end
        S_AVG_DONE: begin
          if (sub == 5'd31) begin
            // Start the rotation for the mean heading.
            prev_heading <= theta;
            cx <= CORDIC_GAIN;
            cy <= '0;
            cz <= z0;
            cflip <= flip0;
            vec_mode <= 1'b0;
            iter <= '0;
            sub <= '0;
            state <= S_AVG_RUN;
          end else begin
            cc <= fin15(cx, cflip);
            sc <= fin15(cy, cflip);
            state <= S_PROD;
            sub <= 5'd16;
          end
        end
        S_PROD: begin
          // Phase 16..18 forms the products, then the inch scaling.
          if (sub == 5'd16) begin
            p1 <= 64'(dm) * 64'(cc);
            sub <= 5'd17;
          end else if (sub == 5'd17) begin
            tx <= p1 - 64'((dl + dr) / 2) * 64'(sc);
            ux <= 2 * p1 - 64'(dl + dr) * 64'(sc);
            p1 <= 64'(dm) * 64'(sc);
            sub <= 5'd18;
          end else if (sub == 5'd18) begin
            ty <= p1 + 64'((dl + dr) / 2) * 64'(cc);
            uy <= 2 * p1 + 64'(dl + dr) * 64'(cc);
            sub <= 5'd0;
            state <= S_ACC;
          end else begin
            sc_hi_p <= 64'(mul_p) << 16;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (sub[1] == 1'b0 && sub[4] == 1'b0) begin
            if (sub[3] == 1'b0) begin
              // First half: high product.
              sub[3] <= 1'b1;
              sub[4] <= 1'b1;
              state <= S_PROD;
            end else begin
              if (sub[0] == 1'b0)
                acc_xi <= acc_xi + 48'(sc_neg ? -sc_ins : sc_ins);
              else
                acc_yi <= acc_yi + 48'(sc_neg ? -sc_ins : sc_ins);
              sub <= {3'b000, 2'(sub[1:0] + 2'd1)};
            end
          end else if (sub[4] == 1'b1) begin
            sub[4] <= 1'b0;
          end else begin
            if (sub[1:0] == 2'd2)
              acc_xt <= acc_xt + 48'(sc_neg ? -sc_tik : sc_tik);
            else
              acc_yt <= acc_yt + 48'(sc_neg ? -sc_tik : sc_tik);
            if (sub[1:0] == 2'd3) state <= S_CDEG;
            sub <= {3'b000, 2'(sub[1:0] + 2'd1)};
          end
        end
        S_CDEG: begin
          if (res_load) begin
            if (16'((mul_p + 60'd32768) >> 16) >= 16'd36000) heading_cdeg <= '0;
            else heading_cdeg <= 16'((mul_p + 60'd32768) >> 16);
            x_ticks <= acc_xt; y_ticks <= acc_yt;
            x_inches <= acc_xi; y_inches <= acc_yi;
            step_left <= st_left; step_right <= st_right; step_middle <= st_middle;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rot_ang = (state == S_SCB_INIT) ? mb : ma;
    if (state == S_AVG_DONE) rot_ang = 16'(avg17);
  end

  // A waiting result holds still until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(x_ticks) && $stable(step_left)))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("input taken while the sequencer is busy");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_CLEAR) |=> (acc_xt == 0 && acc_yi == 0))
    else $error("position not cleared");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import dio_pkg::*;

  localparam int Steps = 16;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 120;

  typedef struct packed {
    logic [15:0]        heading_cdeg;
    logic signed [47:0] x_ticks;
    logic signed [47:0] y_ticks;
    logic signed [47:0] x_inches;
    logic signed [47:0] y_inches;
    logic signed [31:0] step_left;
    logic signed [31:0] step_right;
    logic signed [31:0] step_middle;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid, cfg_ready;
  logic [19:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] func;
  logic signed [31:0] count_left, count_right, count_middle;
  logic [15:0] imu_a_heading, imu_b_heading;
  logic out_valid, out_ready;
  pose_t got;

  dual_imu_encoder_odometry u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .count_left(count_left), .count_right(count_right), .count_middle(count_middle),
    .imu_a_heading(imu_a_heading), .imu_b_heading(imu_b_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .heading_cdeg(got.heading_cdeg), .x_ticks(got.x_ticks), .y_ticks(got.y_ticks),
    .x_inches(got.x_inches), .y_inches(got.y_inches), .step_left(got.step_left),
    .step_right(got.step_right), .step_middle(got.step_middle)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the odometry state, advanced once per accepted input transfer.
  logic [19:0] scale_q16;
  logic [31:0] last_left, last_right, last_middle;
  logic [15:0] last_heading, zero_offset;
  logic [47:0] pos_x_ticks, pos_y_ticks, pos_x_inches, pos_y_inches;

  // Poses still owed by the block, oldest first.
  pose_t pending_poses[$];
  int mismatches = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int stall_cycles = 0;

  // Cumulative counts that the random part walks forward from.
  logic signed [31:0] walk_left = 0, walk_right = 0, walk_middle = 0;

  // Rotation-mode CORDIC giving Q1.15 cosine and sine of a 16-bit turn angle.
  // Angles past a quarter turn are folded by a half turn and negated afterwards.
  function automatic void rotate_unit(input logic [15:0] ang, output longint c,
                                      output longint s);
    int     z32;
    longint z, x, y, xs, ys;
    bit     flip;
    z32  = {ang, 16'h0000};
    z    = z32;
    x    = longint'(CORDIC_GAIN);
    y    = 0;
    flip = 1'b0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < Steps && i < AtanCount; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    x = (x + 16384) >>> 15;
    y = (y + 16384) >>> 15;
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring-mode CORDIC: direction of (sx, sy) in 16-bit turns. A zero
  // vector, which two opposite headings produce, points a half turn away.
  function automatic logic [15:0] vector_angle(input longint sx, input longint sy);
    longint      x, y, xs, ys;
    logic [31:0] z;
    if (sx == 0 && sy == 0) return 16'h8000;
    x = sx * 16384;
    y = sy * 16384;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < Steps && i < AtanCount; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURNS[i];
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic logic [15:0] fuse_headings(input logic [15:0] a, input logic [15:0] b);
    longint ca, sa, cb, sb;
    rotate_unit(a, ca, sa);
    rotate_unit(b, cb, sb);
    return vector_angle(ca + cb, sa + sb);
  endfunction

  // Sensor headings turn the other way, so mirror them before converting to turns.
  function automatic logic [15:0] mirrored_turns(input logic [15:0] h);
    longint m, t;
    m = (h <= 36000) ? 36000 - longint'(h) : longint'(h) - 36000;
    t = (m * 65536 + 18000) / 36000;
    return t[15:0];
  endfunction

  // Shift right with rounding half away from zero.
  function automatic longint shift_round(input longint v, input int n);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -r : r;
  endfunction

  // Multiply by the Q4.16 scale and drop 16 fraction bits, in two halves so
  // that nothing overflows 64 bits.
  function automatic logic [63:0] to_inches(input longint u);
    logic [63:0] mag, hi, lo, r, k;
    k   = 64'(scale_q16);
    mag = (u < 0) ? 64'(-u) : 64'(u);
    hi  = mag >> 32;
    lo  = mag & 64'hFFFFFFFF;
    r   = ((hi * k) << 16) + ((lo * k + 64'h8000) >> 16);
    return (u < 0) ? -r : r;
  endfunction

  function automatic logic [15:0] turns_to_cdeg(input logic [15:0] t);
    int unsigned d;
    d = (int'(t) * 36000 + 32768) >> 16;
    return (d >= 36000) ? 16'd0 : d[15:0];
  endfunction

  // Advances the predicted state by one command and returns the pose the block owes.
  function automatic pose_t advance_pose(input func_t f, input logic [31:0] cl,
                                         input logic [31:0] cr, input logic [31:0] cm,
                                         input logic [15:0] ha, input logic [15:0] hb);
    pose_t       p;
    logic [15:0] ma, mb, theta, mean_ang;
    logic [16:0] ang_sum;
    logic [31:0] sl, sr, sm;
    longint      dl, dr, dm, half, c, s, tx, ty, ux, uy;
    ma = mirrored_turns(ha);
    mb = mirrored_turns(hb);
    sl = '0;
    sr = '0;
    sm = '0;
    case (f)
      FUNC_TICK: begin
        sl = cl - last_left;
        sr = cr - last_right;
        sm = cm - last_middle;
        last_left   = cl;
        last_right  = cr;
        last_middle = cm;
        dl = longint'(signed'(sl));
        dr = longint'(signed'(sr));
        dm = longint'(signed'(sm));
        theta = fuse_headings(ma - zero_offset, mb - zero_offset);
        // The mean of the two headings deliberately ignores wrap-around.
        ang_sum  = {1'b0, theta} + {1'b0, last_heading};
        mean_ang = ang_sum[16:1];
        last_heading = theta;
        rotate_unit(mean_ang, c, s);
        half = (dl + dr) / 2;
        tx = dm * c - half * s;
        ty = dm * s + half * c;
        pos_x_ticks = pos_x_ticks + 48'(shift_round(tx, 7));
        pos_y_ticks = pos_y_ticks + 48'(shift_round(ty, 7));
        ux = 2 * dm * c - (dl + dr) * s;
        uy = 2 * dm * s + (dl + dr) * c;
        pos_x_inches = pos_x_inches + 48'(to_inches(ux));
        pos_y_inches = pos_y_inches + 48'(to_inches(uy));
      end
      FUNC_ZERO: zero_offset = fuse_headings(ma, mb);
      FUNC_CLEAR: begin
        pos_x_ticks  = '0;
        pos_y_ticks  = '0;
        pos_x_inches = '0;
        pos_y_inches = '0;
      end
      default: ;
    endcase
    p.heading_cdeg = turns_to_cdeg(last_heading);
    p.x_ticks      = pos_x_ticks;
    p.y_ticks      = pos_y_ticks;
    p.x_inches     = pos_x_inches;
    p.y_inches     = pos_y_inches;
    p.step_left    = sl;
    p.step_right   = sr;
    p.step_middle  = sm;
    return p;
  endfunction

  // Drives one command at the falling edge, holds it until the transfer, then
  // records the pose it should produce. Valid stays high on return so that
  // back-to-back commands need no gap.
  task automatic send_command(input func_t f, input logic [31:0] cl, input logic [31:0] cr,
                              input logic [31:0] cm, input logic [15:0] ha,
                              input logic [15:0] hb);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    count_left    <= cl;
    count_right   <= cr;
    count_middle  <= cm;
    imu_a_heading <= ha;
    imu_b_heading <= hb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_poses.push_back(advance_pose(f, cl, cr, cm, ha, hb));
  endtask

  // Lets the block drain, then writes the scale register.
  task automatic write_scale(input logic [19:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scale_q16 = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed;
    // A first tick from reset sees the full counts as the change.
    send_command(FUNC_TICK, 32'd100, 32'd120, -32'd40, 16'd0, 16'd0);
    send_command(FUNC_TICK, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd35999, 16'd35999);
    // Counts swinging from the positive to the negative extreme wrap the change.
    send_command(FUNC_TICK, 32'h80000000, 32'h80000000, 32'h80000000, 16'd9000, 16'd9000);
    send_command(FUNC_TICK, 32'h7FFFFFFF, 32'h80000000, 32'h0, 16'd27000, 16'd27000);
    send_command(FUNC_TICK, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'd18000, 16'd17999);
    // Opposite headings cancel to a zero vector.
    send_command(FUNC_TICK, 32'd500, 32'd500, 32'd500, 16'd0, 16'd18000);
    send_command(FUNC_TICK, 32'd900, 32'd700, 32'd100, 16'd9000, 16'd27000);
    // Headings across the wrap make the plain mean land on the far side.
    send_command(FUNC_TICK, 32'd1500, 32'd1300, 32'd300, 16'd100, 16'd35900);
    send_command(FUNC_TICK, 32'd2500, 32'd2300, 32'd200, 16'd35900, 16'd35800);
    send_command(FUNC_ZERO, 32'hAAAAAAAA, 32'h55555555, 32'h12345678, 16'd4500, 16'd4700);
    send_command(FUNC_TICK, 32'd3000, 32'd2900, 32'd250, 16'd4600, 16'd4600);
    send_command(FUNC_ZERO, 32'h0, 32'h0, 32'h0, 16'd0, 16'd18000);
    send_command(FUNC_TICK, 32'd3100, 32'd3050, 32'd260, 16'd1200, 16'd1300);
    send_command(FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 16'd35999, 16'd0);
    send_command(FUNC_TICK, 32'd3300, 32'd3250, 32'd280, 16'd20000, 16'd21000);
    send_command(FUNC_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd35999, 16'd35999);
    send_command(FUNC_ZERO, 32'h0, 32'h0, 32'h0, 16'd0, 16'd0);
    send_command(FUNC_TICK, 32'd3400, 32'd3300, 32'd290, 16'd0, 16'd0);
    walk_left   = 3400;
    walk_right  = 3300;
    walk_middle = 290;
  endtask

  // Mostly ticks with small count changes and two close headings, mixed with
  // offset zeroing, position clears, the unused command and wild count jumps.
  task automatic test_random_drive(input int n, input int sender_idle, input int receiver_idle);
    int          pick;
    func_t       f;
    logic [15:0] ha, hb;
    in_idle_pct  = sender_idle;
    out_idle_pct = receiver_idle;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      f = (pick < 82) ? FUNC_TICK : (pick < 89) ? FUNC_ZERO : (pick < 95) ? FUNC_CLEAR
                                                                        : FUNC_NONE;
      if ($urandom_range(19) == 0) begin
        walk_left   = $urandom;
        walk_right  = $urandom;
        walk_middle = $urandom;
      end else begin
        walk_left   = walk_left + $signed($urandom_range(800)) - 400;
        walk_right  = walk_right + $signed($urandom_range(800)) - 400;
        walk_middle = walk_middle + $signed($urandom_range(300)) - 150;
      end
      ha = 16'($urandom_range(35999));
      if ($urandom_range(9) == 0) hb = 16'($urandom_range(35999));
      else hb = 16'((32'(ha) + 36000 + $urandom_range(600) - 300) % 36000);
      send_command(f, walk_left, walk_right, walk_middle, ha, hb);
    end
  endtask

  // Receiver stalls, re-decided every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Checks each output transfer against the oldest owed pose.
  always @(posedge clk) begin
    pose_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %p", got);
      end else begin
        want = pending_poses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("pose mismatch\n  want %p\n  got  %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    func          = FUNC_TICK;
    count_left    = '0;
    count_right   = '0;
    count_middle  = '0;
    imu_a_heading = '0;
    imu_b_heading = '0;
    out_ready     = 1'b0;
    scale_q16     = 20'd1573;
    last_left     = '0;
    last_right    = '0;
    last_middle   = '0;
    last_heading  = '0;
    zero_offset   = '0;
    pos_x_ticks   = '0;
    pos_y_ticks   = '0;
    pos_x_inches  = '0;
    pos_y_inches  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed commands run at the reset scale, then once more at both extremes.
    test_directed();
    write_scale(20'hFFFFF);
    test_directed();
    write_scale(20'h00000);
    test_directed();

    write_scale(20'd1573);
    test_random_drive(480, 23, 74);
    write_scale(20'($urandom));
    test_random_drive(480, 74, 23);
    write_scale(20'hFFFFF);
    test_random_drive(440, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
